### rtl/core/integer_matrix_multiply_top_assert.svh
// Assertion macros used by the top-level file to check its own behavior.
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/imm_pkg.sv
package imm_pkg;

    localparam int DIM_W     = 4;
    localparam int INDEX_W   = 3;
    localparam int PRODUCT_W = 36;
    localparam int IN_W      = 16;

    typedef enum logic [1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } imm_state_t;

    typedef struct packed {
        logic [DIM_W-1:0] ra;
        logic [DIM_W-1:0] kd;
        logic [DIM_W-1:0] cb;
    } dims_t;

    typedef struct packed {
        logic load_en;
        logic issue;
        logic next_elem;
    } ctrl_cmd_t;

    typedef struct packed {
        logic load_done;
        logic k_last;
        logic pipe_busy;
        logic elem_last;
    } dp_status_t;

endpackage

### rtl/core/integer_matrix_multiply_top.sv
// Integer matrix multiplier. Matrix A (rows_a by inner_dim) and then matrix B
// (inner_dim by cols_b) arrive as one request stream, row-major, one element
// per cycle while loading. Right after the final element of B is taken the
// block stops taking input and delivers every product element in row-major
// order with its row and column index; last marks the final one. For each product
// element the inner terms pass one per cycle through the single multiply-accumulate
// unit fed by one read port on each store; its read, multiply and accumulate stages
// then drain, and the accumulator is held as the product until the output is taken.
// A dimension register holding 0 acts as 1, one above MAX_DIM acts as MAX_DIM.
// Writing any dimension register drops a partly loaded pair of matrices.
`include "integer_matrix_multiply_top_assert.svh"

module integer_matrix_multiply_top #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [imm_pkg::IN_W-1:0]      element,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [imm_pkg::PRODUCT_W-1:0] product,
    output logic [imm_pkg::INDEX_W-1:0]          row_index,
    output logic [imm_pkg::INDEX_W-1:0]          col_index,
    output logic                                 last
);

    localparam int DW = imm_pkg::DIM_W;

    logic [DW-1:0]         rows_a_reg;
    logic [DW-1:0]         inner_dim_reg;
    logic [DW-1:0]         cols_b_reg;
    logic                  load_restart;
    imm_pkg::dims_t        dims;
    imm_pkg::ctrl_cmd_t    cmd;
    imm_pkg::dp_status_t   status;

    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)
        begin
            r = DW'(1);
        end
        else if (v > DW'(MAX_DIM))
        begin
            r = DW'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign load_restart = cfg_we && ((cfg_index == imm_pkg::CFG_ROWS_A)
                                  || (cfg_index == imm_pkg::CFG_INNER_DIM)
                                  || (cfg_index == imm_pkg::CFG_COLS_B));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DW'(8);
            inner_dim_reg <= DW'(8);
            cols_b_reg    <= DW'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imm_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                imm_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                imm_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:                rows_a_reg    <= rows_a_reg;
            endcase
        end
    end

    assign dims.ra = eff_dim(rows_a_reg);
    assign dims.kd = eff_dim(inner_dim_reg);
    assign dims.cb = eff_dim(cols_b_reg);

    imm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    imm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dims         (dims),
        .load_restart (load_restart),
        .cmd          (cmd),
        .element      (element),
        .status       (status),
        .product      (product),
        .row_index    (row_index),
        .col_index    (col_index),
        .last         (last)
    );

    `IMM_ASSERT_SAME(a_no_input_while_output, clk, rst_n, out_valid, !in_ready)
    `IMM_ASSERT_NEXT(a_compute_after_load, clk, rst_n,
        in_valid && in_ready && status.load_done, !in_ready && !out_valid)
    `IMM_ASSERT_SAME(a_last_at_corner, clk, rst_n, out_valid && last,
        (DW'(row_index) == dims.ra - DW'(1)) && (DW'(col_index) == dims.cb - DW'(1)))

endmodule

### rtl/core/imm_ctrl.sv
module imm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   out_ready,
    input  imm_pkg::dp_status_t    status,
    output logic                   in_ready,
    output logic                   out_valid,
    output imm_pkg::ctrl_cmd_t     cmd
);

    imm_pkg::imm_state_t state_reg;
    imm_pkg::imm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imm_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imm_pkg::ST_LOAD:
            begin
                if (in_valid && status.load_done)
                begin
                    state_next = imm_pkg::ST_MAC;
                end
            end
            imm_pkg::ST_MAC:
            begin
                if (status.k_last)
                begin
                    state_next = imm_pkg::ST_DRAIN;
                end
            end
            imm_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = imm_pkg::ST_OUT;
                end
            end
            imm_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = status.elem_last ? imm_pkg::ST_LOAD : imm_pkg::ST_MAC;
                end
            end
            default:
            begin
                state_next = imm_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.load_en   = 1'b0;
        cmd.issue     = 1'b0;
        cmd.next_elem = 1'b0;
        case (state_reg)
            imm_pkg::ST_LOAD:
            begin
                in_ready    = 1'b1;
                cmd.load_en = in_valid;
            end
            imm_pkg::ST_MAC:
            begin
                cmd.issue = 1'b1;
            end
            imm_pkg::ST_DRAIN:
            begin
                cmd.issue = 1'b0;
            end
            imm_pkg::ST_OUT:
            begin
                out_valid     = 1'b1;
                cmd.next_elem = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/imm_datapath.sv
module imm_datapath #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  imm_pkg::dims_t                         dims,
    input  logic                                   load_restart,
    input  imm_pkg::ctrl_cmd_t                     cmd,
    input  logic signed [imm_pkg::IN_W-1:0]        element,
    output imm_pkg::dp_status_t                    status,
    output logic signed [imm_pkg::PRODUCT_W-1:0]   product,
    output logic [imm_pkg::INDEX_W-1:0]            row_index,
    output logic [imm_pkg::INDEX_W-1:0]            col_index,
    output logic                                   last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int IW     = $clog2(MAX_DIM);
    localparam int PW     = 2 * ELEM_WIDTH;
    localparam int DW     = imm_pkg::DIM_W;

    logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
    logic [ELEM_WIDTH-1:0] b_mem [DEPTH];

    logic [ELEM_WIDTH-1:0] elem_ext;

    logic          ld_phase_reg;
    logic [IW-1:0] ld_r_reg;
    logic [IW-1:0] ld_c_reg;
    logic [DW-1:0] row_lim;
    logic [DW-1:0] col_lim;
    logic          ld_row_end;
    logic          ld_col_end;
    logic [AW-1:0] wr_addr;

    logic [IW-1:0] ci_reg;
    logic [IW-1:0] cj_reg;
    logic [IW-1:0] ck_reg;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          ci_end;
    logic          cj_end;
    logic          ck_end;

    logic signed [ELEM_WIDTH-1:0] rd_a_reg;
    logic signed [ELEM_WIDTH-1:0] rd_b_reg;
    logic                         s1_valid_reg;
    logic                         s1_first_reg;
    logic signed [PW-1:0]         prod_reg;
    logic                         s2_valid_reg;
    logic                         s2_first_reg;
    logic signed [63:0]           prod_wide;
    logic [imm_pkg::PRODUCT_W-1:0] acc_reg;

    generate
        if (ELEM_WIDTH <= imm_pkg::IN_W)
        begin : g_narrow
            assign elem_ext = element[ELEM_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign elem_ext = {(ELEM_WIDTH - imm_pkg::IN_W)'(0), element};
        end
    endgenerate

    // A is loaded as ra rows of kd elements, B as kd rows of cb elements.
    assign row_lim    = ld_phase_reg ? dims.kd : dims.ra;
    assign col_lim    = ld_phase_reg ? dims.cb : dims.kd;
    assign ld_row_end = (DW'(ld_r_reg) == row_lim - DW'(1));
    assign ld_col_end = (DW'(ld_c_reg) == col_lim - DW'(1));
    assign wr_addr    = AW'(ld_r_reg * MAX_DIM + ld_c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_phase_reg <= 1'b0;
            ld_r_reg     <= '0;
            ld_c_reg     <= '0;
        end
        else if (load_restart)
        begin
            ld_phase_reg <= 1'b0;
            ld_r_reg     <= '0;
            ld_c_reg     <= '0;
        end
        else if (cmd.load_en)
        begin
            if (ld_col_end)
            begin
                ld_c_reg <= '0;
                if (ld_row_end)
                begin
                    ld_r_reg     <= '0;
                    ld_phase_reg <= !ld_phase_reg;
                end
                else
                begin
                    ld_r_reg <= ld_r_reg + IW'(1);
                end
            end
            else
            begin
                ld_c_reg <= ld_c_reg + IW'(1);
            end
        end
    end

    assign ci_end    = (DW'(ci_reg) == dims.ra - DW'(1));
    assign cj_end    = (DW'(cj_reg) == dims.cb - DW'(1));
    assign ck_end    = (DW'(ck_reg) == dims.kd - DW'(1));
    assign rd_addr_a = AW'(ci_reg * MAX_DIM + ck_reg);
    assign rd_addr_b = AW'(ck_reg * MAX_DIM + cj_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg <= '0;
            cj_reg <= '0;
            ck_reg <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                ck_reg <= ck_end ? '0 : ck_reg + IW'(1);
            end
            if (cmd.next_elem)
            begin
                if (cj_end)
                begin
                    cj_reg <= '0;
                    ci_reg <= ci_end ? '0 : ci_reg + IW'(1);
                end
                else
                begin
                    cj_reg <= cj_reg + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && !ld_phase_reg)
        begin
            a_mem[wr_addr] <= elem_ext;
        end
        if (cmd.load_en && ld_phase_reg)
        begin
            b_mem[wr_addr] <= elem_ext;
        end
        rd_a_reg <= a_mem[rd_addr_a];
        rd_b_reg <= b_mem[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign prod_wide = 64'(prod_reg);

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (ck_reg == '0);
        s2_first_reg <= s1_first_reg;
        prod_reg     <= rd_a_reg * rd_b_reg;
        if (s2_valid_reg)
        begin
            acc_reg <= s2_first_reg ? prod_wide[imm_pkg::PRODUCT_W-1:0]
                                    : acc_reg + prod_wide[imm_pkg::PRODUCT_W-1:0];
        end
    end

    assign status.load_done = ld_phase_reg && ld_row_end && ld_col_end;
    assign status.k_last    = ck_end;
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign status.elem_last = ci_end && cj_end;

    assign product   = signed'(acc_reg);
    assign row_index = imm_pkg::INDEX_W'(ci_reg);
    assign col_index = imm_pkg::INDEX_W'(cj_reg);
    assign last      = ci_end && cj_end;

endmodule

### tb/sv/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DIM_W      = imm_pkg::DIM_W;
    localparam int         IN_W       = imm_pkg::IN_W;
    localparam int         INDEX_W    = imm_pkg::INDEX_W;
    localparam int         PRODUCT_W  = imm_pkg::PRODUCT_W;
    localparam int         MAX_DIM    = 8;
    localparam int         STORE_SIZE = MAX_DIM * MAX_DIM;
    localparam int         HOLD_CYCLES = 300;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [PRODUCT_W-1:0] product;
        logic [INDEX_W-1:0]          row;
        logic [INDEX_W-1:0]          col;
        logic                        last;
    } product_elem_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [1:0]                  cfg_index;
    logic [DIM_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [IN_W-1:0]      element;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [PRODUCT_W-1:0] product;
    logic [INDEX_W-1:0]          row_index;
    logic [INDEX_W-1:0]          col_index;
    logic                        last;

    logic [DIM_W-1:0]       dim_rows;
    logic [DIM_W-1:0]       dim_inner;
    logic [DIM_W-1:0]       dim_cols;
    logic signed [IN_W-1:0] a_matrix [STORE_SIZE];
    logic signed [IN_W-1:0] b_matrix [STORE_SIZE];
    int unsigned            fill_count;

    product_elem_t expected_products [$];

    event hold_start;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int error_count;
    int elements_sent;
    int products_checked;
    int register_writes;
    int largest_burst;

    integer_matrix_multiply_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .element   (element),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .product   (product),
        .row_index (row_index),
        .col_index (col_index),
        .last      (last)
    );

    always #5 clk = ~clk;

    function automatic int unsigned effective_size(input logic [DIM_W-1:0] value);
        if (value == 0)
        begin
            return 1;
        end
        if (value > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return 32'(value);
    endfunction

    function automatic void apply_register(input logic [1:0] index, input logic [DIM_W-1:0] value);
        case (index)
            imm_pkg::CFG_ROWS_A:
            begin
                dim_rows = value;
                fill_count = 0;
            end
            imm_pkg::CFG_INNER_DIM:
            begin
                dim_inner = value;
                fill_count = 0;
            end
            imm_pkg::CFG_COLS_B:
            begin
                dim_cols = value;
                fill_count = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void store_and_multiply(input logic signed [IN_W-1:0] value);
        int unsigned   ra;
        int unsigned   kd;
        int unsigned   cb;
        int unsigned   a_count;
        int unsigned   total;
        int unsigned   c;
        int unsigned   d;
        longint        acc;
        product_elem_t elem;
        ra = effective_size(dim_rows);
        kd = effective_size(dim_inner);
        cb = effective_size(dim_cols);
        a_count = ra * kd;
        total = a_count + kd * cb;
        c = fill_count;
        if (c >= total)
        begin
            c = 0;
        end
        if (c < a_count)
        begin
            a_matrix[((c / kd) * MAX_DIM + (c % kd)) % STORE_SIZE] = value;
        end
        else
        begin
            d = c - a_count;
            b_matrix[((d / cb) * MAX_DIM + (d % cb)) % STORE_SIZE] = value;
        end
        c++;
        if (c < total)
        begin
            fill_count = c;
            return;
        end
        fill_count = 0;
        for (int unsigned i = 0; i < ra; i++)
        begin
            for (int unsigned j = 0; j < cb; j++)
            begin
                acc = 0;
                for (int unsigned k = 0; k < kd; k++)
                begin
                    acc += longint'(a_matrix[(i * MAX_DIM + k) % STORE_SIZE])
                         * longint'(b_matrix[(k * MAX_DIM + j) % STORE_SIZE]);
                end
                elem.product = acc[PRODUCT_W-1:0];
                elem.row = i[INDEX_W-1:0];
                elem.col = j[INDEX_W-1:0];
                elem.last = (i == ra - 1) && (j == cb - 1);
                expected_products.push_back(elem);
            end
        end
        if (ra * cb > largest_burst)
        begin
            largest_burst = ra * cb;
        end
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim_value();
        int r;
        r = $urandom_range(99);
        if (r < 85)
        begin
            return DIM_W'($urandom_range(1, 3));
        end
        if (r < 92)
        begin
            return 0;
        end
        return DIM_W'($urandom_range(8, 15));
    endfunction

    function automatic logic [IN_W-1:0] random_element();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_element(input logic [IN_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        element <= value;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        store_and_multiply(value);
        elements_sent++;
        @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [DIM_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_register(index, value);
        register_writes++;
        @(negedge clk);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] kd,
                              input logic [DIM_W-1:0] cb);
        write_register(imm_pkg::CFG_ROWS_A, ra);
        write_register(imm_pkg::CFG_INNER_DIM, kd);
        write_register(imm_pkg::CFG_COLS_B, cb);
    endtask

    // Waits until every expected product has come out, then lets the pipeline settle.
    task automatic wait_drained();
        while (expected_products.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(negedge clk);
    endtask

    task automatic test_single_element_extremes();
        write_dims(1, 1, 1);
        send_element(16'h8000);
        send_element(16'h8000);
        send_element(16'h7FFF);
        send_element(16'h8000);
        send_element(16'h7FFF);
        send_element(16'h7FFF);
        send_element(16'h0000);
        send_element(16'hFFFF);
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_zero_dims();
        write_dims(0, 0, 0);
        send_element(16'h5A5A);
        send_element(16'hA5A5);
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_dropped_load();
        write_dims(2, 2, 2);
        send_element(16'h1234);
        send_element(16'hEDCB);
        send_element(16'h7FFF);
        in_valid <= 1'b0;
        wait_drained();
        write_register(imm_pkg::CFG_INNER_DIM, 2);
        for (int n = 0; n < 8; n++)
        begin
            send_element(random_element());
        end
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_unlisted_register();
        write_dims(1, 2, 1);
        send_element(16'h8000);
        send_element(16'h0003);
        in_valid <= 1'b0;
        repeat (3) @(negedge clk);
        write_register(CFG_UNUSED, 15);
        send_element(16'h7FFF);
        send_element(16'hFFFE);
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random_loads(input int item_goal);
        int          start_count;
        int unsigned total;
        int unsigned count;
        bit          first;
        start_count = elements_sent;
        first = 1'b1;
        while (elements_sent - start_count < item_goal)
        begin
            if (first || $urandom_range(99) < 70)
            begin
                in_valid <= 1'b0;
                wait_drained();
                if ($urandom_range(9) == 0)
                begin
                    write_register(CFG_UNUSED, DIM_W'($urandom));
                end
                write_dims(pick_dim_value(), pick_dim_value(), pick_dim_value());
            end
            first = 1'b0;
            total = effective_size(dim_rows) * effective_size(dim_inner)
                  + effective_size(dim_inner) * effective_size(dim_cols);
            count = total;
            if ($urandom_range(9) == 0)
            begin
                count = $urandom_range(1, total - 1);
            end
            for (int unsigned n = 0; n < count; n++)
            begin
                send_element(random_element());
            end
        end
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_largest_dims();
        write_dims(8, 8, 8);
        for (int n = 0; n < 128; n++)
        begin
            send_element(16'h8000);
        end
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_receiver_backpressure();
        write_dims(15, 0, 9);
        -> hold_start;
        for (int n = 0; n < 32; n++)
        begin
            send_element(random_element());
        end
        in_valid <= 1'b0;
        wait_drained();
    endtask

    always
    begin
        @(hold_start);
        hold_left = HOLD_CYCLES;
        while (hold_left > 0)
        begin
            @(posedge clk);
            hold_left = hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        product_elem_t want;
        if (rst_n && out_valid && out_ready)
        begin
            products_checked++;
            if (expected_products.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("unexpected product %0d at row %0d col %0d", product, row_index,
                             col_index);
                end
            end
            else
            begin
                want = expected_products.pop_front();
                if (product !== want.product || row_index !== want.row
                    || col_index !== want.col || last !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("mismatch: expected product %0d row %0d col %0d last %0b",
                                 want.product, want.row, want.col, want.last);
                        $display("          got      product %0d row %0d col %0d last %0b",
                                 product, row_index, col_index, last);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        element = '0;
        out_ready = 1'b0;
        dim_rows = 8;
        dim_inner = 8;
        dim_cols = 8;
        fill_count = 0;
        for (int n = 0; n < STORE_SIZE; n++)
        begin
            a_matrix[n] = '0;
            b_matrix[n] = '0;
        end
        elements_sent = 0;
        register_writes = 0;
        largest_burst = 0;
        send_idle_pct = 6;
        recv_idle_pct = 73;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_element_extremes();
        test_zero_dims();
        test_dropped_load();
        test_unlisted_register();
        test_random_loads(12);

        send_idle_pct = 73;
        recv_idle_pct = 6;
        test_random_loads(12);
        test_largest_dims();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_receiver_backpressure();
        test_random_loads(12);

        wait_drained();
        $display("Sent %0d elements and checked %0d product elements over %0d register writes.",
                 elements_sent, products_checked, register_writes);
        $display("Largest product burst was %0d elements; %0d mismatches.", largest_burst,
                 error_count);
        if (error_count == 0 && expected_products.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/imm_pkg.sv
rtl/core/imm_ctrl.sv
rtl/core/imm_datapath.sv
rtl/core/integer_matrix_multiply_top.sv
tb/sv/testbench.sv
